/* rtl/v3n_pkg.sv */
package v3n_pkg;

    localparam int UNIT_WIDTH = 16;
    localparam int LEN_WIDTH  = 16;

    typedef struct packed {
        logic [UNIT_WIDTH-1:0] unit_x;
        logic [UNIT_WIDTH-1:0] unit_y;
        logic [UNIT_WIDTH-1:0] unit_z;
        logic [LEN_WIDTH-1:0]  length;
        logic                  is_null;
    } v3n_result_t;

endpackage

/* rtl/v3n_sqrt.sv */
module v3n_sqrt
    import v3n_pkg::*;
#(
    parameter int IN_WIDTH  = 32,
    parameter int OUT_WIDTH = 16,
    parameter int TAG_WIDTH = 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [IN_WIDTH-1:0]  radicand,
    input  logic [TAG_WIDTH-1:0] in_tag,
    output logic                 out_valid,
    output logic [OUT_WIDTH-1:0] root,
    output logic [TAG_WIDTH-1:0] out_tag
);

    // one result bit per stage, restoring square root
    localparam int STAGES = OUT_WIDTH;
    localparam int RW     = OUT_WIDTH + 2;
    localparam int NW     = 2 * OUT_WIDTH;

    logic [NW-1:0]        n_reg   [STAGES+1];
    logic [RW-1:0]        r_reg   [STAGES+1];
    logic [OUT_WIDTH-1:0] q_reg   [STAGES+1];
    logic [TAG_WIDTH-1:0] tag_reg [STAGES+1];
    logic [STAGES:0]      vld_reg;

    always_comb
    begin
        n_reg[0]   = NW'(radicand);
        r_reg[0]   = '0;
        q_reg[0]   = '0;
        tag_reg[0] = in_tag;
        vld_reg[0] = in_valid;
    end

    genvar g;
    generate
        for (g = 0; g < STAGES; g++)
        begin : g_stage
            logic [RW-1:0] trial;
            logic [RW-1:0] rem_shift;
            logic [RW-1:0] r_next;
            logic [OUT_WIDTH-1:0] q_next;

            always_comb
            begin
                rem_shift = {r_reg[g][RW-3:0], n_reg[g][NW-1 -: 2]};
                trial     = {q_reg[g], 2'b01};
                if (rem_shift >= trial)
                begin
                    r_next = rem_shift - trial;
                    q_next = {q_reg[g][OUT_WIDTH-2:0], 1'b1};
                end
                else
                begin
                    r_next = rem_shift;
                    q_next = {q_reg[g][OUT_WIDTH-2:0], 1'b0};
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[g+1] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[g+1] <= vld_reg[g];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    n_reg[g+1]   <= {n_reg[g][NW-3:0], 2'b00};
                    r_reg[g+1]   <= r_next;
                    q_reg[g+1]   <= q_next;
                    tag_reg[g+1] <= tag_reg[g];
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[STAGES];
    assign root      = q_reg[STAGES];
    assign out_tag   = tag_reg[STAGES];

endmodule

/* rtl/v3n_div.sv */
module v3n_div
    import v3n_pkg::*;
#(
    parameter int SUM_WIDTH = 34,
    parameter int Q_WIDTH   = 29,
    parameter int TAG_WIDTH = 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [SUM_WIDTH-1:0] num,
    input  logic [SUM_WIDTH-1:0] den,
    input  logic [TAG_WIDTH-1:0] in_tag,
    output logic                 out_valid,
    output logic [Q_WIDTH-1:0]   quot,
    output logic [TAG_WIDTH-1:0] out_tag
);

    // one quotient bit per stage; num <= den so first bit is num >= den
    localparam int STAGES = Q_WIDTH;
    localparam int RW     = SUM_WIDTH + 1;

    logic [RW-1:0]        r_reg   [STAGES+1];
    logic [SUM_WIDTH-1:0] d_reg   [STAGES+1];
    logic [Q_WIDTH-1:0]   q_reg   [STAGES+1];
    logic [TAG_WIDTH-1:0] tag_reg [STAGES+1];
    logic [STAGES:0]      vld_reg;

    always_comb
    begin
        r_reg[0]   = RW'(num);
        d_reg[0]   = den;
        q_reg[0]   = '0;
        tag_reg[0] = in_tag;
        vld_reg[0] = in_valid;
    end

    genvar g;
    generate
        for (g = 0; g < STAGES; g++)
        begin : g_stage
            logic [RW-1:0] cur;
            logic [RW-1:0] r_next;
            logic          bit_q;

            always_comb
            begin
                if (g == 0)
                    cur = r_reg[g];
                else
                    cur = {r_reg[g][RW-2:0], 1'b0};
                bit_q  = (cur >= RW'(d_reg[g]));
                r_next = bit_q ? (cur - RW'(d_reg[g])) : cur;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[g+1] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[g+1] <= vld_reg[g];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    r_reg[g+1]   <= r_next;
                    d_reg[g+1]   <= d_reg[g];
                    q_reg[g+1]   <= {q_reg[g][Q_WIDTH-2:0], bit_q};
                    tag_reg[g+1] <= tag_reg[g];
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[STAGES];
    assign quot      = q_reg[STAGES];
    assign out_tag   = tag_reg[STAGES];

endmodule

/* rtl/v3n_lane.sv */
module v3n_lane
    import v3n_pkg::*;
#(
    parameter int COMP_WIDTH = 16,
    parameter int FRAC_BITS  = 14,
    parameter int SUM_WIDTH  = 34
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [2*COMP_WIDTH-1:0] sq,
    input  logic [SUM_WIDTH-1:0]   sum,
    input  logic                   neg,
    output logic                   out_valid,
    output logic [UNIT_WIDTH-1:0]  unit
);

    // quotient < 2^(2F+1), root <= 2^F
    localparam int Q_WIDTH = 2 * FRAC_BITS + 1;
    localparam int R_WIDTH = FRAC_BITS + 1;
    localparam int Q_EVEN  = 2 * R_WIDTH;

    logic               div_valid;
    logic [Q_WIDTH-1:0] quot;
    logic               div_neg;
    logic               sq_valid;
    logic [R_WIDTH-1:0] root;
    logic               root_neg;
    logic [UNIT_WIDTH-1:0] mag;

    v3n_div #(
        .SUM_WIDTH (SUM_WIDTH),
        .Q_WIDTH   (Q_WIDTH),
        .TAG_WIDTH (1)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .num       (SUM_WIDTH'(sq)),
        .den       (sum),
        .in_tag    (neg),
        .out_valid (div_valid),
        .quot      (quot),
        .out_tag   (div_neg)
    );

    v3n_sqrt #(
        .IN_WIDTH  (Q_EVEN),
        .OUT_WIDTH (R_WIDTH),
        .TAG_WIDTH (1)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (div_valid),
        .radicand  (Q_EVEN'(quot)),
        .in_tag    (div_neg),
        .out_valid (sq_valid),
        .root      (root),
        .out_tag   (root_neg)
    );

    assign mag       = UNIT_WIDTH'(root);
    assign out_valid = sq_valid;
    assign unit      = root_neg ? (UNIT_WIDTH'(0) - mag) : mag;

endmodule

/* rtl/vector3_normalize.sv */
// path from input beat to output beat: stage 1, stage 2, lane divider, lane square root, output register
// throughput: one beat per cycle while not stalled; every stage is a pipeline register of the lanes
// the pipeline holds while the output register is full and not taken
// reset: rst_n asynchronous, active low, clears all valid flags; no payload state
module vector3_normalize
    import v3n_pkg::*;
#(
    parameter int COMP_WIDTH = 16,
    parameter int FRAC_BITS  = 14
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // vec_x, vec_y, vec_z
    input  logic [((3*COMP_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // unit_x, unit_y, unit_z, length, is_null, zero fill
    output logic [71:0]               m_tdata
);

    localparam int SQ_WIDTH  = 2 * COMP_WIDTH;
    localparam int SUM_WIDTH = SQ_WIDTH + 2;
    localparam int ROOT_W    = SUM_WIDTH / 2;
    localparam int LAT_LANE  = 2 * FRAC_BITS + 1 + FRAC_BITS + 1;

    logic en;
    logic in_fire;

    logic [COMP_WIDTH-1:0] comp  [3];
    logic [COMP_WIDTH-1:0] mag   [3];
    logic                  negs  [3];

    // stage 1: magnitudes and squares
    logic                  s1_valid_reg;
    logic [SQ_WIDTH-1:0]   s1_sq_reg  [3];
    logic                  s1_neg_reg [3];
    // stage 2: sum
    logic                  s2_valid_reg;
    logic [SQ_WIDTH-1:0]   s2_sq_reg  [3];
    logic                  s2_neg_reg [3];
    logic [SUM_WIDTH-1:0]  s2_sum_reg;

    logic [2:0]            lane_valid;
    logic [UNIT_WIDTH-1:0] lane_unit [3];
    logic                  len_valid;
    logic [ROOT_W-1:0]     len_root;
    logic                  len_null;

    logic [LAT_LANE-ROOT_W-1:0] null_dly_reg;
    logic [LAT_LANE-ROOT_W-1:0] vld_dly_reg;
    logic [ROOT_W-1:0]          len_dly_reg [LAT_LANE-ROOT_W];

    logic                  out_valid_reg;
    v3n_result_t           out_reg;
    v3n_result_t           out_next;

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;
    assign in_fire  = s_tvalid && s_tready;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            comp[i] = s_tdata[i*COMP_WIDTH +: COMP_WIDTH];
            negs[i] = comp[i][COMP_WIDTH-1];
            mag[i]  = negs[i] ? (COMP_WIDTH'(0) - comp[i]) : comp[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_fire;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                s1_sq_reg[i]  <= SQ_WIDTH'(mag[i]) * SQ_WIDTH'(mag[i]);
                s1_neg_reg[i] <= negs[i];
                s2_sq_reg[i]  <= s1_sq_reg[i];
                s2_neg_reg[i] <= s1_neg_reg[i];
            end
            s2_sum_reg <= SUM_WIDTH'(s1_sq_reg[0]) + SUM_WIDTH'(s1_sq_reg[1])
                        + SUM_WIDTH'(s1_sq_reg[2]);
        end
    end

    genvar g;
    generate
        for (g = 0; g < 3; g++)
        begin : g_lane
            v3n_lane #(
                .COMP_WIDTH (COMP_WIDTH),
                .FRAC_BITS  (FRAC_BITS),
                .SUM_WIDTH  (SUM_WIDTH)
            ) u_lane (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (en),
                .in_valid  (s2_valid_reg),
                .sq        (s2_sq_reg[g]),
                .sum       ((s2_sum_reg == '0) ? SUM_WIDTH'(1) : s2_sum_reg),
                .neg       (s2_neg_reg[g]),
                .out_valid (lane_valid[g]),
                .unit      (lane_unit[g])
            );
        end
    endgenerate

    v3n_sqrt #(
        .IN_WIDTH  (SUM_WIDTH),
        .OUT_WIDTH (ROOT_W),
        .TAG_WIDTH (1)
    ) u_len (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s2_valid_reg),
        .radicand  (s2_sum_reg),
        .in_tag    (s2_sum_reg == '0),
        .out_valid (len_valid),
        .root      (len_root),
        .out_tag   (len_null)
    );

    // align length path with the lanes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_dly_reg <= '0;
        end
        else if (en)
        begin
            vld_dly_reg <= {vld_dly_reg[LAT_LANE-ROOT_W-2:0], len_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            null_dly_reg   <= {null_dly_reg[LAT_LANE-ROOT_W-2:0], len_null};
            len_dly_reg[0] <= len_root;
            for (int i = 1; i < LAT_LANE - ROOT_W; i++)
                len_dly_reg[i] <= len_dly_reg[i-1];
        end
    end

    // merge lanes; zero vector forces zero units
    always_comb
    begin
        out_next.is_null = null_dly_reg[LAT_LANE-ROOT_W-1];
        out_next.length  = LEN_WIDTH'(len_dly_reg[LAT_LANE-ROOT_W-1]);
        out_next.unit_x  = out_next.is_null ? '0 : lane_unit[0];
        out_next.unit_y  = out_next.is_null ? '0 : lane_unit[1];
        out_next.unit_z  = out_next.is_null ? '0 : lane_unit[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= lane_valid[0] && vld_dly_reg[LAT_LANE-ROOT_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_reg.is_null, out_reg.length, out_reg.unit_z,
                       out_reg.unit_y, out_reg.unit_x};

endmodule

/* sim/vector3_normalize_tb.sv */
module vector3_normalize_tb;
    import v3n_pkg::*;

    typedef struct {
        logic [15:0] vx;
        logic [15:0] vy;
        logic [15:0] vz;
        bit          typed;
        logic [71:0] res;
    } vec_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;

    logic [71:0] unit_q[$];
    int          errors;
    bit          stim_done;
    vec_row_t    dir_rows[$];

    vector3_normalize uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #5 clk = ~clk;

    function automatic logic [63:0] root64(logic [63:0] n);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [71:0] normalize(logic [15:0] vx, logic [15:0] vy,
                                              logic [15:0] vz);
        logic signed [15:0] c[3];
        logic [63:0]        mag[3];
        logic [63:0]        sum;
        logic [63:0]        u;
        logic [15:0]        unit[3];
        c[0] = vx;
        c[1] = vy;
        c[2] = vz;
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = c[i] < 0 ? 64'(-32'(c[i])) : 64'(c[i]);
            sum += mag[i] * mag[i];
        end
        if (sum == 0)
            return {7'd0, 1'b1, 16'd0, 16'd0, 16'd0, 16'd0};
        for (int i = 0; i < 3; i++)
        begin
            // mag^2 < 2^31, so shifting by 28 fits in 64 bits
            u = root64(((mag[i] * mag[i]) << 28) / sum);
            unit[i] = c[i] < 0 ? 16'(-u) : u[15:0];
        end
        u = root64(sum);
        return {7'd0, 1'b0, u[15:0], unit[2], unit[1], unit[0]};
    endfunction

    // tdata fields from lowest bit up
    function automatic logic [71:0] pack_res(logic [15:0] ux, logic [15:0] uy,
                                             logic [15:0] uz, logic [15:0] len,
                                             logic nul);
        return {7'd0, nul, len, uz, uy, ux};
    endfunction

    task automatic add_row(int x, int y, int z, bit typed = 0,
                           logic [71:0] res = '0);
        vec_row_t r;
        r.vx = x[15:0];
        r.vy = y[15:0];
        r.vz = z[15:0];
        r.typed = typed;
        r.res = res;
        dir_rows.push_back(r);
    endtask

    task automatic send_vec(logic [15:0] vx, logic [15:0] vy, logic [15:0] vz,
                            bit typed, logic [71:0] res);
        s_tvalid <= 1'b1;
        s_tdata <= {vz, vy, vx};
        unit_q.push_back(typed ? res : normalize(vx, vy, vz));
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic gap;
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6))
            @(posedge clk);
    endtask

    initial
    begin
        clk = 0;
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        errors = 0;
        stim_done = 0;
        add_row(0, 0, 0, 1, pack_res(0, 0, 0, 0, 1));
        add_row(1, 0, 0, 1, pack_res(16384, 0, 0, 1, 0));
        add_row(-1, 0, 0, 1, pack_res(16'hC000, 0, 0, 1, 0));
        add_row(0, 32767, 0, 1, pack_res(0, 16384, 0, 32767, 0));
        add_row(0, 0, -32768, 1, pack_res(0, 0, 16'hC000, 32768, 0));
        add_row(-32768, -32768, -32768, 1,
                pack_res(16'hDB0D, 16'hDB0D, 16'hDB0D, 56755, 0));
        add_row(32767, 32767, 32767);
        add_row(-32768, 32767, -32768);
        add_row(3, 4, 0, 1, pack_res(9830, 13107, 0, 5, 0));
        add_row(1, 1, 1);
        add_row(-1, 1, -1);
        add_row(1, 32767, 0);
        add_row(-32768, 1, 1);
        add_row(16'h5555, 16'hAAAA, 16'h0F0F);
        add_row(16'hAAAA, 16'h5555, 16'hF0F0);
        add_row(0, 0, 1, 1, pack_res(0, 0, 16384, 1, 0));
        repeat (10)
            @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        foreach (dir_rows[i])
        begin
            send_vec(dir_rows[i].vx, dir_rows[i].vy, dir_rows[i].vz,
                     dir_rows[i].typed, dir_rows[i].res);
            if ($urandom_range(0, 3) == 0)
                gap();
        end
        for (int n = 0; n < 1300; )
        begin
            int burst;
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst; k++)
            begin
                logic [15:0] v[3];
                for (int j = 0; j < 3; j++)
                begin
                    case ($urandom_range(0, 5))
                        0: v[j] = 16'($urandom_range(0, 7)) - 16'd3;
                        1: v[j] = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
                        2: v[j] = 16'd0;
                        default: v[j] = $urandom;
                    endcase
                end
                send_vec(v[0], v[1], v[2], 0, '0);
                n++;
            end
            if ($urandom_range(0, 2) != 0)
                gap();
        end
        s_tvalid <= 1'b0;
        stim_done = 1;
    end

    initial
    begin
        m_tready = 0;
        @(posedge rst_n);
        forever
        begin
            int mode;
            mode = $urandom_range(0, 2);
            repeat ($urandom_range(1, 30))
            begin
                @(posedge clk);
                m_tready <= mode == 0 ? 1'b1 :
                            mode == 1 ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 1));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (unit_q.size() == 0)
            begin
                $error("unexpected beat %h", m_tdata);
                errors++;
            end
            else
            begin
                logic [71:0] e;
                e = unit_q.pop_front();
                if (m_tdata[15:0] !== e[15:0])
                begin
                    $error("unit_x expected %h actual %h", e[15:0], m_tdata[15:0]);
                    errors++;
                end
                if (m_tdata[31:16] !== e[31:16])
                begin
                    $error("unit_y expected %h actual %h", e[31:16], m_tdata[31:16]);
                    errors++;
                end
                if (m_tdata[47:32] !== e[47:32])
                begin
                    $error("unit_z expected %h actual %h", e[47:32], m_tdata[47:32]);
                    errors++;
                end
                if (m_tdata[63:48] !== e[63:48])
                begin
                    $error("length expected %0d actual %0d", e[63:48], m_tdata[63:48]);
                    errors++;
                end
                if (m_tdata[64] !== e[64])
                begin
                    $error("is_null expected %b actual %b", e[64], m_tdata[64]);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        wait (stim_done);
        while (unit_q.size() != 0)
            @(posedge clk);
        repeat (100)
            @(posedge clk);
        if (errors == 0 && unit_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("status: fail");
        $finish;
    end
endmodule

/* sim.f */
rtl/v3n_pkg.sv
rtl/v3n_sqrt.sv
rtl/v3n_div.sv
rtl/v3n_lane.sv
rtl/vector3_normalize.sv
sim/vector3_normalize_tb.sv
